[sv/lzd_pkg.sv]
// ----------------------------------------------------------------------------
// LZ77 match decoder package
// Shared constants and item types of the LZ77 match decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

   localparam int HISTORY_DEPTH  = 4096;
   localparam int MAX_MATCH      = 64;
   localparam int ADDR_BITS      = $clog2(HISTORY_DEPTH);
   localparam int FILL_BITS      = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_BITS       = $clog2(MAX_MATCH + 1);

   localparam int LEN_BITS       = 7;
   localparam int DIST_BITS      = 13;
   localparam int SYM_BITS       = 8;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_BITS   = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_BITS   = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [LEN_BITS-1:0]  match_length;
      logic [DIST_BITS-1:0] distance;
      logic [SYM_BITS-1:0]  literal;
   } req_type;

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                last;
      logic                error;
   } rsp_type;

endpackage

[sv/lz77_match_decoder_unit.sv]
// ----------------------------------------------------------------------------
// LZ77 match decoder
// Expands literal and match tokens into symbols through a circular history.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------
//   req_     | in        | req_valid/req_ready  | req_item (req_type)
//   rsp_     | out       | rsp_valid/rsp_ready  | rsp_item (rsp_type)
//
// A literal or rejected token passes through the p1 stage into the result queue; a
// match of length L copies L symbols, one symbol per cycle while the result queue has space,
// read from the history memory, which has one read port and one write port.
// Reset clears the write position and the fill count; history contents are
// left as they are. A stalled result channel holds generation once the
// four-entry result queue cannot take the symbol in flight.
module lz77_match_decoder_unit
   import lzd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_COPY = 1'b1;

   logic [SYM_BITS-1:0]     hist_mem [HISTORY_DEPTH];

   logic                    state_ff;
   logic                    state_in;
   logic [ADDR_BITS-1:0]    wp_ff;
   logic [ADDR_BITS-1:0]    wp_in;
   logic [FILL_BITS-1:0]    fill_ff;
   logic [FILL_BITS-1:0]    fill_in;
   logic [ADDR_BITS-1:0]    rp_ff;
   logic [ADDR_BITS-1:0]    rp_in;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [CNT_BITS-1:0]     cnt_in;

   logic                    p1_valid_ff;
   logic                    p1_valid_in;
   logic                    p1_use_mem_ff;
   logic                    p1_use_mem_in;
   logic                    p1_write_ff;
   logic                    p1_write_in;
   rsp_type                 p1_rsp_ff;
   rsp_type                 p1_rsp_in;

   logic [SYM_BITS-1:0]     rd_data_ff;
   logic                    fwd_ff;
   logic [SYM_BITS-1:0]     fwd_data_ff;

   logic [RSP_CNT_BITS-1:0] fifo_count;
   logic                    space;
   logic                    accept;
   logic                    wr_en;
   logic [SYM_BITS-1:0]     wr_data;
   logic [CNT_BITS-1:0]     len_sat;
   logic                    dist_bad;
   rsp_type                 push_item;

   assign space = (32'(fifo_count) + 32'(p1_valid_ff)) < RSP_FIFO_DEPTH;
   assign req_ready = (state_ff == ST_IDLE) && !p1_valid_ff && space;
   assign accept = req_valid && req_ready;

   assign len_sat = (32'(req_item.match_length) > MAX_MATCH) ?
                    CNT_BITS'(MAX_MATCH) : CNT_BITS'(req_item.match_length);
   assign dist_bad = (req_item.distance == '0) ||
                     (32'(req_item.distance) > 32'(fill_ff));

   assign wr_data = p1_use_mem_ff ? (fwd_ff ? fwd_data_ff : rd_data_ff)
                                  : p1_rsp_ff.symbol;
   assign wr_en   = p1_valid_ff && p1_write_ff;

   always_comb begin
      push_item        = p1_rsp_ff;
      push_item.symbol = wr_data;
   end

   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      cnt_in        = cnt_ff;
      p1_valid_in   = 1'b0;
      p1_use_mem_in = p1_use_mem_ff;
      p1_write_in   = p1_write_ff;
      p1_rsp_in     = p1_rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.match_length == '0) begin
                  p1_valid_in   = 1'b1;
                  p1_use_mem_in = 1'b0;
                  p1_write_in   = 1'b1;
                  p1_rsp_in     = '{symbol: req_item.literal, last: 1'b1, error: 1'b0};
               end else if (dist_bad) begin
                  p1_valid_in   = 1'b1;
                  p1_use_mem_in = 1'b0;
                  p1_write_in   = 1'b0;
                  p1_rsp_in     = '{symbol: '0, last: 1'b1, error: 1'b1};
               end else begin
                  rp_in    = wp_ff - ADDR_BITS'(req_item.distance);
                  cnt_in   = len_sat;
                  state_in = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (space) begin
               p1_valid_in   = 1'b1;
               p1_use_mem_in = 1'b1;
               p1_write_in   = 1'b1;
               p1_rsp_in     = '{symbol: '0, last: (cnt_ff == CNT_BITS'(1)), error: 1'b0};
               rp_in         = rp_ff + 1'b1;
               cnt_in        = cnt_ff - 1'b1;
               if (cnt_ff == CNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (wr_en) begin
         wp_in = wp_ff + 1'b1;
         if (32'(fill_ff) != HISTORY_DEPTH) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         fill_ff     <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff         <= rp_in;
      cnt_ff        <= cnt_in;
      p1_use_mem_ff <= p1_use_mem_in;
      p1_write_ff   <= p1_write_in;
      p1_rsp_ff     <= p1_rsp_in;
   end

   // A read of the slot being written in the same cycle takes the new symbol.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wp_ff] <= wr_data;
      end
      rd_data_ff  <= hist_mem[rp_ff];
      fwd_ff      <= wr_en && (rp_ff == wp_ff);
      fwd_data_ff <= wr_data;
   end

   lzd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (p1_valid_ff),
      .push_item (push_item),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

[sv/lzd_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// LZ77 match decoder result queue
// Small result queue that decouples symbol generation from the result channel.
// ----------------------------------------------------------------------------
module lzd_rsp_fifo
   import lzd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rsp_type                 push_item,
   output logic [RSP_CNT_BITS-1:0] count,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_item
);

   rsp_type                 slot_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff;
   logic [RSP_CNT_BITS-1:0] count_ff;
   logic [RSP_PTR_BITS-1:0] wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_in;
   logic                    pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
